>>> sv/hfea_pkg.sv
// shared types, constants and tables for the euler homography unit
`default_nettype none
package hfea_pkg;

	// field widths
	localparam int ANG_W = 16;
	localparam int CTR_W = 16;
	localparam int FOC_W = 20;
	localparam int OUT_W = 48;
	localparam int NUM_ANG = 3;

	// default number of cordic steps
	localparam int CORDIC_ITER_DEF = 24;

	// angle pipeline depth
	localparam int ANG_LAT = 4;

	// degree constants in Q8.7
	localparam logic signed [16:0] DEG90 = 17'sd11520;
	localparam logic signed [16:0] DEG180 = 17'sd23040;
	localparam logic signed [16:0] DEG360 = 17'sd46080;

	// pi in Q30 split as PI_A * 23040 + PI_B
	localparam logic [17:0] PI_A = 18'd146408;
	localparam logic [14:0] PI_B = 15'd19106;
	// reciprocal of 45, exact for 19-bit dividends with a shift of 25
	localparam logic [19:0] DIV45_K = 20'd745655;
	localparam int DIV45_SH = 25;

	// cordic start value, Q2.30
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// focal distance after reset, Q16.4
	localparam logic [FOC_W-1:0] FOCAL_RESET = 20'd65536;

	typedef logic signed [ANG_W-1:0] angle_t;
	typedef logic signed [32:0] zang_t;
	typedef logic signed [32:0] q30_t;
	typedef logic signed [OUT_W-1:0] hval_t;

	// arctangent table, Q30 radians
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] a;
		case (i)
			0: a = 32'h3243F6A8;
			1: a = 32'h1DAC6705;
			2: a = 32'h0FADBAFC;
			3: a = 32'h07F56EA6;
			4: a = 32'h03FEAB76;
			5: a = 32'h01FFD55B;
			6: a = 32'h00FFFAAA;
			7: a = 32'h007FFF55;
			8: a = 32'h003FFFEA;
			9: a = 32'h001FFFFD;
			10: a = 32'h000FFFFF;
			11: a = 32'h0007FFFF;
			12: a = 32'h0003FFFF;
			13: a = 32'h0001FFFF;
			14: a = 32'h0000FFFF;
			15: a = 32'h00007FFF;
			16: a = 32'h00003FFF;
			17: a = 32'h00001FFF;
			18: a = 32'h00000FFF;
			19: a = 32'h000007FF;
			20: a = 32'h000003FF;
			21: a = 32'h000001FF;
			22: a = 32'h000000FF;
			23: a = 32'h0000007F;
			24: a = 32'h0000003F;
			25: a = 32'h0000001F;
			26: a = 32'h0000000F;
			27: a = 32'h00000008;
			28: a = 32'h00000004;
			29: a = 32'h00000002;
			30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// q30 product rounded half up back to q30
	function automatic q30_t mul30(input q30_t a, input q30_t b);
		logic signed [65:0] p;
		p = a * b + 66'sd536870912;
		return p[62:30];
	endfunction

endpackage
`default_nettype wire

>>> sv/homography_from_euler_angles_unit.sv
// top level of the euler angle to perspective homography unit
// The unit takes roll, pitch and yaw (Q8.7 degrees) and a rotation center
// (Q12.4 pixels) and returns the 3x3 homography A2*T*R*A1 as Q31.16 entries,
// clipped to 48 bits with a flag. One beat is accepted every cycle while no
// result beat is held under stall; a result passes through the angle conversion
// stages, one cordic stage per step and the matrix product and rounding stages.
// The whole pipeline holds while a result beat waits under stall. The focal
// distance
// register takes writes at any time but should only change while idle.
`default_nettype none
module homography_from_euler_angles_unit import hfea_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire angle_t           roll_deg,
	input  wire angle_t           pitch_deg,
	input  wire angle_t           yaw_deg,
	input  wire logic [CTR_W-1:0] pivot_x,
	input  wire logic [CTR_W-1:0] pivot_y,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output hval_t                 h00,
	output hval_t                 h01,
	output hval_t                 h02,
	output hval_t                 h10,
	output hval_t                 h11,
	output hval_t                 h12,
	output hval_t                 h20,
	output hval_t                 h21,
	output hval_t                 h22,
	output logic                  saturated,
	input  wire logic             focal_valid,
	output logic                  focal_ready,
	input  wire logic [FOC_W-1:0] focal_distance
);

	localparam int CTR_LAT = ANG_LAT + CORDIC_ITERATIONS + 1;

	logic en;
	logic [FOC_W-1:0] focal_q;

	// pipeline advances unless a result beat is held
	assign en = !(result_valid && result_stall);
	assign item_stall = !en;
	assign focal_ready = 1'b1;

	// focal distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RESET;
		end else if (focal_valid) begin
			focal_q <= focal_distance;
		end
	end

	// angle conversion
	angle_t ang [NUM_ANG];
	zang_t  z [NUM_ANG];
	logic   neg [NUM_ANG];
	logic   z_valid;
	assign ang[0] = roll_deg;
	assign ang[1] = pitch_deg;
	assign ang[2] = yaw_deg;

	hfea_angle u_angle (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (item_valid),
		.ang     (ang),
		.z_valid (z_valid),
		.z       (z),
		.neg     (neg)
	);

	// sine and cosine
	q30_t sin_v [NUM_ANG];
	q30_t cos_v [NUM_ANG];
	logic sc_valid;

	hfea_cordic #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (z_valid),
		.z        (z),
		.neg      (neg),
		.sc_valid (sc_valid),
		.sin_v    (sin_v),
		.cos_v    (cos_v)
	);

	// center delay matched to the angle path
	logic [CTR_W-1:0] cx_sn [CTR_LAT];
	logic [CTR_W-1:0] cy_sn [CTR_LAT];
	always_ff @(posedge clk) begin
		if (en) begin
			cx_sn[0] <= pivot_x;
			cy_sn[0] <= pivot_y;
			for (int k = 1; k < CTR_LAT; k++) begin
				cx_sn[k] <= cx_sn[k-1];
				cy_sn[k] <= cy_sn[k-1];
			end
		end
	end

	// matrix assembly
	hfea_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (sc_valid),
		.sin_v     (sin_v),
		.cos_v     (cos_v),
		.cx        (cx_sn[CTR_LAT-1]),
		.cy        (cy_sn[CTR_LAT-1]),
		.f         (focal_q),
		.h_valid   (result_valid),
		.h00       (h00),
		.h01       (h01),
		.h02       (h02),
		.h10       (h10),
		.h11       (h11),
		.h12       (h12),
		.h20       (h20),
		.h21       (h21),
		.h22       (h22),
		.saturated (saturated)
	);

	// clipping flag implies some entry other than h20 and h21 sits at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && saturated) |->
		(h00 == 48'sh7FFFFFFFFFFF || h00 == 48'sh800000000000 ||
		 h01 == 48'sh7FFFFFFFFFFF || h01 == 48'sh800000000000 ||
		 h02 == 48'sh7FFFFFFFFFFF || h02 == 48'sh800000000000 ||
		 h10 == 48'sh7FFFFFFFFFFF || h10 == 48'sh800000000000 ||
		 h11 == 48'sh7FFFFFFFFFFF || h11 == 48'sh800000000000 ||
		 h12 == 48'sh7FFFFFFFFFFF || h12 == 48'sh800000000000 ||
		 h22 == 48'sh7FFFFFFFFFFF || h22 == 48'sh800000000000))
		else $error("saturated set with no entry clipped");

	// perspective row of a rotation stays near unit size
	a_persp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (h20 <= 48'sd70000 && h20 >= -48'sd70000 &&
			h21 <= 48'sd70000 && h21 >= -48'sd70000))
		else $error("perspective entry out of rotation range");

	// a held result keeps its last column and its saturation flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(h02) &&
			$stable(h12) && $stable(h22) && $stable(saturated)))
		else $error("held result changed");

endmodule
`default_nettype wire

>>> sv/hfea_angle.sv
// angle wrap, quadrant fold and degree to q30 radian conversion, three lanes
`default_nettype none
module hfea_angle import hfea_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   valid,
	input  wire angle_t ang [NUM_ANG],
	output logic        z_valid,
	output zang_t       z [NUM_ANG],
	output logic        neg [NUM_ANG]
);

	logic v_s1, v_s2, v_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			z_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			z_valid <= v_s3;
		end
	end

	for (genvar l = 0; l < NUM_ANG; l++) begin : g_lane
		logic signed [16:0] d0, d1, d2;
		logic        fold;
		logic [13:0] mag_s1;
		logic        zneg_s1, neg_s1, zneg_s2, neg_s2, zneg_s3, neg_s3;
		logic [31:0] qa_s2, qa_s3;
		logic [27:0] xb_s2;
		logic [13:0] quot_s3;
		logic [38:0] prod;
		logic [31:0] q;

		// wrap to [-180,180) then fold into [-90,90]
		always_comb begin
			d0 = 17'(ang[l]);
			if (d0 >= DEG180) begin
				d1 = d0 - DEG360;
			end else if (d0 < -DEG180) begin
				d1 = d0 + DEG360;
			end else begin
				d1 = d0;
			end
			fold = 1'b0;
			if (d1 > DEG90) begin
				d2 = d1 - DEG180;
				fold = 1'b1;
			end else if (d1 < -DEG90) begin
				d2 = d1 + DEG180;
				fold = 1'b1;
			end else begin
				d2 = d1;
			end
		end

		// quotient by 23040 taken as 512 then 45
		assign prod = 39'(xb_s2[27:9]) * 39'(DIV45_K);
		assign q = qa_s3 + 32'(quot_s3);

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s1 <= d2[16] ? 14'(-d2) : d2[13:0];
				zneg_s1 <= d2[16];
				neg_s1 <= fold;
				qa_s2 <= 32'(mag_s1) * 32'(PI_A);
				xb_s2 <= 28'(mag_s1) * 28'(PI_B) + 28'(DEG90);
				zneg_s2 <= zneg_s1;
				neg_s2 <= neg_s1;
				qa_s3 <= qa_s2;
				quot_s3 <= prod[38:DIV45_SH];
				zneg_s3 <= zneg_s2;
				neg_s3 <= neg_s2;
				z[l] <= zneg_s3 ? -$signed({1'b0, q}) : $signed({1'b0, q});
				neg[l] <= neg_s3;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/hfea_cordic.sv
// rotation-mode cordic, one stage per step, three lanes
`default_nettype none
module hfea_cordic import hfea_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  valid,
	input  wire zang_t z [NUM_ANG],
	input  wire logic  neg [NUM_ANG],
	output logic       sc_valid,
	output q30_t       sin_v [NUM_ANG],
	output q30_t       cos_v [NUM_ANG]
);

	localparam int N = CORDIC_ITERATIONS;

	logic v_sn [N];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) v_sn[k] <= 1'b0;
			sc_valid <= 1'b0;
		end else if (en) begin
			v_sn[0] <= valid;
			for (int k = 1; k < N; k++) v_sn[k] <= v_sn[k-1];
			sc_valid <= v_sn[N-1];
		end
	end

	for (genvar l = 0; l < NUM_ANG; l++) begin : g_lane
		logic signed [33:0] x_sn [N];
		logic signed [33:0] y_sn [N];
		logic signed [32:0] z_sn [N];
		logic               neg_sn [N];

		for (genvar k = 0; k < N; k++) begin : g_step
			logic signed [33:0] xp, yp;
			logic signed [32:0] zp, a;
			logic               np;

			if (k == 0) begin : g_first
				assign xp = CORDIC_GAIN;
				assign yp = '0;
				assign zp = z[l];
				assign np = neg[l];
			end else begin : g_next
				assign xp = x_sn[k-1];
				assign yp = y_sn[k-1];
				assign zp = z_sn[k-1];
				assign np = neg_sn[k-1];
			end
			assign a = $signed({1'b0, atan_q30(k)});

			// one micro-rotation
			always_ff @(posedge clk) begin
				if (en) begin
					if (zp >= 0) begin
						x_sn[k] <= xp - (yp >>> k);
						y_sn[k] <= yp + (xp >>> k);
						z_sn[k] <= zp - a;
					end else begin
						x_sn[k] <= xp + (yp >>> k);
						y_sn[k] <= yp - (xp >>> k);
						z_sn[k] <= zp + a;
					end
					neg_sn[k] <= np;
				end
			end
		end

		// undo the half-turn fold
		always_ff @(posedge clk) begin
			if (en) begin
				cos_v[l] <= neg_sn[N-1] ? 33'(-x_sn[N-1]) : 33'(x_sn[N-1]);
				sin_v[l] <= neg_sn[N-1] ? 33'(-y_sn[N-1]) : 33'(y_sn[N-1]);
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/hfea_matrix.sv
// rotation products, homography entries, rounding and saturation
`default_nettype none
module hfea_matrix import hfea_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             valid,
	input  wire q30_t             sin_v [NUM_ANG],
	input  wire q30_t             cos_v [NUM_ANG],
	input  wire logic [CTR_W-1:0] cx,
	input  wire logic [CTR_W-1:0] cy,
	input  wire logic [FOC_W-1:0] f,
	output logic                  h_valid,
	output hval_t                 h00,
	output hval_t                 h01,
	output hval_t                 h02,
	output hval_t                 h10,
	output hval_t                 h11,
	output hval_t                 h12,
	output hval_t                 h20,
	output hval_t                 h21,
	output hval_t                 h22,
	output logic                  saturated
);

	localparam logic signed [55:0] HALF14 = 56'sd8192;
	localparam logic signed [55:0] HALF18 = 56'sd131072;
	localparam logic signed [59:0] HALF8 = 60'sd128;
	localparam logic signed [59:0] SAT_HI = 60'sd140737488355327;
	localparam logic signed [59:0] SAT_LO = -60'sd140737488355328;

	// clip to 48 bits, flag in the top bit
	function automatic logic [OUT_W:0] sat48(input logic signed [59:0] v);
		logic [OUT_W:0] r;
		if (v > SAT_HI) begin
			r = {1'b1, SAT_HI[OUT_W-1:0]};
		end else if (v < SAT_LO) begin
			r = {1'b1, SAT_LO[OUT_W-1:0]};
		end else begin
			r = {1'b0, v[OUT_W-1:0]};
		end
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
			h_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			h_valid <= v_s8;
		end
	end

	// stage 1: first products of sines and cosines
	q30_t sasb_s1, casb_s1, cbcg_s1, cbsg_s1, casg_s1, cacg_s1, sasg_s1, sacg_s1;
	q30_t sg_s1, cg_s1;
	logic [CTR_W-1:0] cx_s1, cy_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			sasb_s1 <= mul30(sin_v[0], sin_v[1]);
			casb_s1 <= mul30(cos_v[0], sin_v[1]);
			cbcg_s1 <= mul30(cos_v[1], cos_v[2]);
			cbsg_s1 <= mul30(cos_v[1], sin_v[2]);
			casg_s1 <= mul30(cos_v[0], sin_v[2]);
			cacg_s1 <= mul30(cos_v[0], cos_v[2]);
			sasg_s1 <= mul30(sin_v[0], sin_v[2]);
			sacg_s1 <= mul30(sin_v[0], cos_v[2]);
			sg_s1 <= sin_v[2];
			cg_s1 <= cos_v[2];
			cx_s1 <= cx;
			cy_s1 <= cy;
		end
	end

	// stage 2: second products
	q30_t t1_s2, t2_s2, t3_s2, t4_s2, r00_s2, r01_s2;
	q30_t casg_s2, cacg_s2, sasg_s2, sacg_s2;
	logic [CTR_W-1:0] cx_s2, cy_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			t1_s2 <= mul30(sasb_s1, cg_s1);
			t2_s2 <= mul30(sasb_s1, sg_s1);
			t3_s2 <= mul30(casb_s1, cg_s1);
			t4_s2 <= mul30(casb_s1, sg_s1);
			r00_s2 <= cbcg_s1;
			r01_s2 <= -cbsg_s1;
			casg_s2 <= casg_s1;
			cacg_s2 <= cacg_s1;
			sasg_s2 <= sasg_s1;
			sacg_s2 <= sacg_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
		end
	end

	// stage 3: rotation entries
	q30_t r00_s3, r01_s3, r10_s3, r11_s3, r20_s3, r21_s3;
	logic [CTR_W-1:0] cx_s3, cy_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			r00_s3 <= r00_s2;
			r01_s3 <= r01_s2;
			r10_s3 <= casg_s2 - t1_s2;
			r11_s3 <= cacg_s2 + t2_s2;
			r20_s3 <= sasg_s2 + t3_s2;
			r21_s3 <= sacg_s2 - t4_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
		end
	end

	// stage 4: products with center and focal distance
	logic signed [17:0] cxs, cys;
	logic signed [21:0] fs;
	assign cxs = $signed({2'b00, cx_s3});
	assign cys = $signed({2'b00, cy_s3});
	assign fs = $signed({2'b00, f});

	logic signed [55:0] pcx20_s4, pcy21_s4, pf00_s4, pcx21_s4, pf01_s4, pf10_s4;
	logic signed [55:0] pcy20_s4, pf11_s4, pcx00_s4, pcy01_s4, pcx10_s4, pcy11_s4;
	q30_t r20_s4, r21_s4;
	logic [CTR_W-1:0] cx_s4, cy_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			pcx20_s4 <= cxs * r20_s3;
			pcy21_s4 <= cys * r21_s3;
			pf00_s4 <= fs * r00_s3;
			pcx21_s4 <= cxs * r21_s3;
			pf01_s4 <= fs * r01_s3;
			pf10_s4 <= fs * r10_s3;
			pcy20_s4 <= cys * r20_s3;
			pf11_s4 <= fs * r11_s3;
			pcx00_s4 <= cxs * r00_s3;
			pcy01_s4 <= cys * r01_s3;
			pcx10_s4 <= cxs * r10_s3;
			pcy11_s4 <= cys * r11_s3;
			r20_s4 <= r20_s3;
			r21_s4 <= r21_s3;
			cx_s4 <= cx_s3;
			cy_s4 <= cy_s3;
		end
	end

	// stage 5: sums in Q34
	logic signed [55:0] fq34;
	assign fq34 = $signed(56'(f)) <<< 30;

	logic signed [55:0] w_s5, h00_s5, h01_s5, h10_s5, h11_s5, g0_s5, g1_s5;
	q30_t r20_s5, r21_s5;
	logic [CTR_W-1:0] cx_s5, cy_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			w_s5 <= fq34 - pcx20_s4 - pcy21_s4;
			h00_s5 <= pf00_s4 + pcx20_s4;
			h01_s5 <= pf01_s4 + pcx21_s4;
			h10_s5 <= pf10_s4 + pcy20_s4;
			h11_s5 <= pf11_s4 + pcy21_s4;
			g0_s5 <= pcx00_s4 + pcy01_s4;
			g1_s5 <= pcx10_s4 + pcy11_s4;
			r20_s5 <= r20_s4;
			r21_s5 <= r21_s4;
			cx_s5 <= cx_s4;
			cy_s5 <= cy_s4;
		end
	end

	// stage 6: rounding
	logic signed [55:0] w20_r, g0_r, g1_r;
	assign w20_r = (w_s5 + HALF14) >>> 14;
	assign g0_r = (g0_s5 + HALF14) >>> 14;
	assign g1_r = (g1_s5 + HALF14) >>> 14;

	logic signed [39:0] w20_s6;
	logic signed [35:0] g0_s6, g1_s6;
	logic signed [55:0] h00_s6, h01_s6, h10_s6, h11_s6, h20_s6, h21_s6, h22_s6;
	logic [CTR_W-1:0] cx_s6, cy_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			w20_s6 <= w20_r[39:0];
			g0_s6 <= g0_r[35:0];
			g1_s6 <= g1_r[35:0];
			h00_s6 <= (h00_s5 + HALF18) >>> 18;
			h01_s6 <= (h01_s5 + HALF18) >>> 18;
			h10_s6 <= (h10_s5 + HALF18) >>> 18;
			h11_s6 <= (h11_s5 + HALF18) >>> 18;
			h20_s6 <= (56'(r20_s5) + HALF14) >>> 14;
			h21_s6 <= (56'(r21_s5) + HALF14) >>> 14;
			h22_s6 <= (w_s5 + HALF18) >>> 18;
			cx_s6 <= cx_s5;
			cy_s6 <= cy_s5;
		end
	end

	// stage 7: partial products for the translation column
	logic [35:0] cxwl_s7, cywl_s7;
	logic signed [36:0] cxwh_s7, cywh_s7;
	logic [39:0] fg0l_s7, fg1l_s7;
	logic signed [36:0] fg0h_s7, fg1h_s7;
	logic signed [55:0] h00_s7, h01_s7, h10_s7, h11_s7, h20_s7, h21_s7, h22_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			cxwl_s7 <= 36'(cx_s6) * 36'(w20_s6[19:0]);
			cywl_s7 <= 36'(cy_s6) * 36'(w20_s6[19:0]);
			cxwh_s7 <= $signed({1'b0, cx_s6}) * $signed(w20_s6[39:20]);
			cywh_s7 <= $signed({1'b0, cy_s6}) * $signed(w20_s6[39:20]);
			fg0l_s7 <= 40'(f) * 40'(g0_s6[19:0]);
			fg1l_s7 <= 40'(f) * 40'(g1_s6[19:0]);
			fg0h_s7 <= $signed({1'b0, f}) * $signed(g0_s6[35:20]);
			fg1h_s7 <= $signed({1'b0, f}) * $signed(g1_s6[35:20]);
			h00_s7 <= h00_s6;
			h01_s7 <= h01_s6;
			h10_s7 <= h10_s6;
			h11_s7 <= h11_s6;
			h20_s7 <= h20_s6;
			h21_s7 <= h21_s6;
			h22_s7 <= h22_s6;
		end
	end

	// stage 8: combine partials, translation column in Q24
	logic signed [59:0] cxw, cyw, fg0, fg1;
	assign cxw = (60'(cxwh_s7) <<< 20) + $signed({24'd0, cxwl_s7});
	assign cyw = (60'(cywh_s7) <<< 20) + $signed({24'd0, cywl_s7});
	assign fg0 = (60'(fg0h_s7) <<< 20) + $signed({20'd0, fg0l_s7});
	assign fg1 = (60'(fg1h_s7) <<< 20) + $signed({20'd0, fg1l_s7});

	logic signed [59:0] d02_s8, d12_s8;
	logic signed [55:0] h00_s8, h01_s8, h10_s8, h11_s8, h20_s8, h21_s8, h22_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			d02_s8 <= cxw - fg0;
			d12_s8 <= cyw - fg1;
			h00_s8 <= h00_s7;
			h01_s8 <= h01_s7;
			h10_s8 <= h10_s7;
			h11_s8 <= h11_s7;
			h20_s8 <= h20_s7;
			h21_s8 <= h21_s7;
			h22_s8 <= h22_s7;
		end
	end

	// stage 9: final rounding and clipping into the output register
	logic [OUT_W:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	assign e00 = sat48(60'(h00_s8));
	assign e01 = sat48(60'(h01_s8));
	assign e02 = sat48((d02_s8 + HALF8) >>> 8);
	assign e10 = sat48(60'(h10_s8));
	assign e11 = sat48(60'(h11_s8));
	assign e12 = sat48((d12_s8 + HALF8) >>> 8);
	assign e20 = sat48(60'(h20_s8));
	assign e21 = sat48(60'(h21_s8));
	assign e22 = sat48(60'(h22_s8));

	always_ff @(posedge clk) begin
		if (en) begin
			h00 <= e00[OUT_W-1:0];
			h01 <= e01[OUT_W-1:0];
			h02 <= e02[OUT_W-1:0];
			h10 <= e10[OUT_W-1:0];
			h11 <= e11[OUT_W-1:0];
			h12 <= e12[OUT_W-1:0];
			h20 <= e20[OUT_W-1:0];
			h21 <= e21[OUT_W-1:0];
			h22 <= e22[OUT_W-1:0];
			saturated <= e00[OUT_W] | e01[OUT_W] | e02[OUT_W] | e10[OUT_W] | e11[OUT_W]
				| e12[OUT_W] | e20[OUT_W] | e21[OUT_W] | e22[OUT_W];
		end
	end

endmodule
`default_nettype wire
